[design/sdl_pkg.sv]
// ----------------------------------------------------------------------------
// sdl_pkg
// Shared types and constants for the sprite draw list builder.
// ----------------------------------------------------------------------------
package sdl_pkg;

    localparam int          MAX_CELLS_DEF = 40;
    localparam int          BUDGET_W      = 6;

    // function codes carried on the input tuser
    localparam logic        FUNC_LINE     = 1'b0;
    localparam logic        FUNC_SPRITE   = 1'b1;

    localparam logic [10:0] X_OFFSET      = 11'd128;
    localparam logic [10:0] X_MASKED      = 11'h780;   // -128
    localparam logic [10:0] X_STEP        = 11'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW1,
        S_ROW2,
        S_BASE,
        S_EMIT
    } t_state;

    // operand selection for the shared add/subtract unit
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        sub;
    } t_alu_op;

endpackage

[design/sprite_draw_list_build.sv]
// ----------------------------------------------------------------------------
// sprite_draw_list_build
// Turns the sprites found for a scanline into per-cell draw entries.
// ----------------------------------------------------------------------------
// Input stream (s side): tuser = func, tdata = line, sprite_y, size_code,
// tile_word, x_raw. A line-start beat reloads the cell budget from the
// configuration register and clears the mask flags; it yields no output.
// A sprite beat is captured, then the shared adder works out the pattern
// row and base address in the states S_ROW1, S_ROW2 and S_BASE, then one
// cell is emitted per cycle (1 to 4 cells) while the sink does not stall.
// The adder is reused for row, base and the per-cell address step.
// s_tready is high only while the sequencer is idle.
// Output stream (m side): one beat per cell, tlast on the final beat of the
// sprite; tuser = cell_valid. A sprite seen with no budget left skips the
// adder and gives a single beat with cell_valid low and dot_overflow high.
// The output register holds a beat until the sink takes it; a stall freezes
// the sequencer in its emit state, and the next input is taken as soon as the
// last beat of a sprite is loaded, even if the sink has not taken it yet.
// Reset: budget and flags clear, cell_budget returns to MAX_CELLS. The
// configuration channel is always ready; it must be written only while idle,
// and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sprite_draw_list_build
    import sdl_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BUDGET_W-1:0] i_cfg_data,     // cell_budget

    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [55:0]         i_s_tdata,      // line, sprite_y, size_code,
                                                // tile_word, x_raw, zero fill
    input  logic [0:0]          i_s_tuser,      // func

    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [39:0]         o_m_tdata,      // cell_address, x_pos,
                                                // palette_prio, h_flip,
                                                // dot_overflow, zero fill
    output logic [0:0]          o_m_tuser,      // cell_valid
    output logic                o_m_tlast
);

    // input field split
    logic [7:0]  w_line;
    logic [10:0] w_y;
    logic [7:0]  w_size;
    logic [15:0] w_tile;
    logic [9:0]  w_xraw;

    assign w_line = i_s_tdata[7:0];
    assign w_y    = i_s_tdata[18:8];
    assign w_size = i_s_tdata[26:19];
    assign w_tile = i_s_tdata[42:27];
    assign w_xraw = i_s_tdata[52:43];

    t_state r_state, n_state;

    logic [BUDGET_W-1:0] r_cfg_budget;
    logic [BUDGET_W-1:0] r_budget, n_budget;
    logic                r_can_mask, n_can_mask;
    logic                r_masked, n_masked;
    logic                r_ovf, n_ovf;

    // per-sprite working registers
    logic [7:0]  r_target;
    logic [7:0]  r_y8;
    logic [4:0]  r_hm1;
    logic [1:0]  r_h;
    logic        r_vflip;
    logic [10:0] r_pattern;
    logic [2:0]  r_pal;
    logic        r_hf;
    logic        r_empty;
    logic [2:0]  r_ncells;
    logic [1:0]  r_count;
    logic [7:0]  r_acc;
    logic [15:0] r_addr;
    logic [10:0] r_x;

    // output register
    logic        r_out_valid;
    logic        r_o_cellv;
    logic [15:0] r_o_addr;
    logic [10:0] r_o_x;
    logic [6:0]  r_o_pal;
    logic        r_o_hf;
    logic        r_o_ovf;
    logic        r_o_last;

    logic        w_s_acc;
    logic        w_line_acc;
    logic        w_spr_acc;
    logic        w_out_free;
    logic        w_emit;
    logic        w_last_cell;
    logic [2:0]  w_width;
    logic [7:0]  w_stride;
    logic [10:0] w_x_init;
    logic        w_plain;
    t_alu_op     w_op;
    logic [15:0] w_sum;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_line_acc = w_s_acc && (i_s_tuser[0] == FUNC_LINE);
    assign w_spr_acc  = w_s_acc && (i_s_tuser[0] == FUNC_SPRITE);

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign w_last_cell = ({1'b0, r_count} + 3'd1) == r_ncells;
    assign w_plain     = !r_empty && !r_masked;

    assign w_width  = {1'b0, w_size[3:2]} + 3'd1;
    assign w_stride = {({1'b0, r_h} + 3'd1), 5'b0};   // height * 4
    assign w_x_init = {1'b0, w_xraw} - X_OFFSET
                    + (w_tile[11] ? {6'b0, w_size[3:2], 3'b0} : 11'd0);

    // shared add/subtract unit
    assign w_sum = w_op.a + (w_op.sub ? ~w_op.b : w_op.b) + {15'b0, w_op.sub};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_spr_acc) begin
                    n_state = (r_budget == '0) ? S_EMIT : S_ROW1;
                end
            end
            S_ROW1: n_state = S_ROW2;
            S_ROW2: n_state = S_BASE;
            S_BASE: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free && w_last_cell) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // adder operand selection
    always_comb begin
        w_op = '0;
        unique case (r_state)
            S_ROW1: begin
                // vflip: y + height - 1, else target
                w_op.a = {8'b0, (r_vflip ? r_y8 : r_target)};
                w_op.b = r_vflip ? {11'b0, r_hm1} : 16'd0;
            end
            S_ROW2: begin
                w_op.a   = {8'b0, r_acc};
                w_op.b   = {8'b0, (r_vflip ? r_target : r_y8)};
                w_op.sub = 1'b1;
            end
            S_BASE: begin
                w_op.a = {r_pattern, 5'b0};
                w_op.b = {6'b0, r_acc, 2'b0};
            end
            S_EMIT: begin
                w_op.a = r_addr;
                w_op.b = {8'b0, w_stride};
            end
            default: w_op = '0;
        endcase
    end

    // line flags
    always_comb begin
        n_budget   = r_budget;
        n_can_mask = r_can_mask;
        n_masked   = r_masked;
        n_ovf      = r_ovf;
        if (w_line_acc) begin
            n_budget   = r_cfg_budget;
            n_can_mask = 1'b0;
            n_masked   = 1'b0;
        end else if (w_spr_acc) begin
            if (r_budget == '0) begin
                n_ovf = 1'b1;
            end else begin
                if (w_xraw != '0) begin
                    n_can_mask = 1'b1;
                end else if (r_can_mask || r_ovf) begin
                    n_masked = 1'b1;
                end
                n_ovf = (r_budget < {3'b0, w_width});
            end
        end else if (w_emit && !r_empty) begin
            n_budget = r_budget - BUDGET_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_budget <= BUDGET_W'(MAX_CELLS);
            r_budget     <= '0;
            r_can_mask   <= 1'b0;
            r_masked     <= 1'b0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_budget   <= n_budget;
            r_can_mask <= n_can_mask;
            r_masked   <= n_masked;
            r_ovf      <= n_ovf;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_budget <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_spr_acc) begin
            r_target  <= w_line + 8'd1;
            r_y8      <= w_y[7:0];
            r_h       <= w_size[1:0];
            r_hm1     <= {w_size[1:0], 3'b111};
            r_vflip   <= w_tile[12];
            r_pattern <= w_tile[10:0];
            r_pal     <= w_tile[15:13];
            r_hf      <= w_tile[11];
            r_x       <= w_x_init;
            r_count   <= '0;
            r_empty   <= (r_budget == '0);
            if (r_budget == '0) begin
                r_ncells <= 3'd1;
            end else if (r_budget < {3'b0, w_width}) begin
                r_ncells <= r_budget[2:0];
            end else begin
                r_ncells <= w_width;
            end
        end
        if (r_state == S_ROW1 || r_state == S_ROW2) begin
            r_acc <= w_sum[7:0];
        end
        if (r_state == S_BASE) begin
            r_addr <= w_sum;
        end
        if (w_emit) begin
            r_count   <= r_count + 2'd1;
            r_addr    <= w_sum;
            r_x       <= r_hf ? (r_x - X_STEP) : (r_x + X_STEP);
            r_o_cellv <= !r_empty;
            r_o_addr  <= w_plain ? r_addr : 16'd0;
            r_o_x     <= r_empty ? 11'd0 : (r_masked ? X_MASKED : r_x);
            r_o_pal   <= w_plain ? {r_pal, 4'b0} : 7'd0;
            r_o_hf    <= w_plain && r_hf;
            r_o_ovf   <= r_ovf;
            r_o_last  <= w_last_cell;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_o_ovf, r_o_hf, r_o_pal, r_o_x, r_o_addr};
    assign o_m_tuser  = r_o_cellv;
    assign o_m_tlast  = r_o_last;

    // a beat without a cell is always the single, overflowing result
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tlast && o_m_tdata[35]))
        else $error("empty-budget beat without tlast or overflow");

    // cell counter stays inside the cell count of the sprite
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ({1'b0, r_count} < r_ncells))
        else $error("cell counter out of range");

    // budget only grows at a line start
    a_budget_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_budget <= $past(r_budget)))
        else $error("budget grew outside a line start");

    // no new cell loaded while the sink stalls a pending beat
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_o_addr)
                                          && $stable(r_o_last)))
        else $error("output beat overwritten under stall");

endmodule
